### design/grdm_pkg.sv
package grdm_pkg;

  localparam int DATA_W   = 24;  // Q4.20 store entries
  localparam int VALUE_W  = 48;  // Q16.32 result
  localparam int CFG_W    = 5;
  localparam int MA_W     = 32;  // shared multiplier, operand A
  localparam int PROD_W   = MA_W + DATA_W;
  localparam int GG_W     = 52;  // Q.32 operand of the Q.20 scaling multiply
  localparam int ACC_W    = 64;

  localparam logic [CFG_W-1:0] NUM_ORBITALS_RST = 5'd16;
  localparam logic [CFG_W-1:0] NUM_PAIRS_RST    = 5'd8;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RDM1 = 2'd1;
  localparam logic [1:0] FUNC_RDM2 = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic CFG_NUM_ORBITALS = 1'b0;
  localparam logic CFG_NUM_PAIRS    = 1'b1;

  localparam logic signed [ACC_W-1:0] ONE_Q32 = 64'sd4294967296;
  localparam logic signed [66:0] SAT_MAX = 67'sd140737488355327;
  localparam logic signed [66:0] SAT_MIN = -67'sd140737488355328;

  typedef struct packed {
    logic [1:0]               func;
    logic [3:0]               index_p;
    logic [3:0]               index_q;
    logic [3:0]               index_r;
    logic [3:0]               index_s;
    logic signed [DATA_W-1:0] coefficient;
    logic signed [DATA_W-1:0] multiplier;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_PRE2, S_SCAN, S_R1, S_R2, S_R3, S_M1, S_M2, S_M3,
    S_M4, S_M5, S_M6, S_ACC, S_RES, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    JOB_PASS, JOB_PI_OV, JOB_PI_VO
  } job_t;

  typedef enum logic [2:0] {
    P_ROW1, P_ROW2, P_COL, P_FS, P_XSUM, P_VV, P_OV
  } pass_t;

  typedef enum logic [1:0] {
    SC_X2, SC_X4, SC_NEG2
  } scale_t;

endpackage

### design/grdm_store.sv
module grdm_store #(
  parameter int IW = 4
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [2*IW-1:0]                   waddr,
  input  logic signed [grdm_pkg::DATA_W-1:0] wcf,
  input  logic signed [grdm_pkg::DATA_W-1:0] wmu,
  input  logic [2*IW-1:0]                   raddr,
  output logic signed [grdm_pkg::DATA_W-1:0] rcf_r,
  output logic signed [grdm_pkg::DATA_W-1:0] rmu_r
);
  import grdm_pkg::*;

  localparam int DEPTH = 1 << (2 * IW);

  logic signed [DATA_W-1:0] cf_mem [DEPTH];
  logic signed [DATA_W-1:0] mu_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cf_mem[waddr] <= wcf;
      mu_mem[waddr] <= wmu;
    end
  end

  always_ff @(posedge clk) begin
    rcf_r <= cf_mem[raddr];
    rmu_r <= mu_mem[raddr];
  end

endmodule

### design/grdm_mul.sv
module grdm_mul (
  input  logic                               clk,
  input  logic signed [grdm_pkg::MA_W-1:0]   a,
  input  logic signed [grdm_pkg::DATA_W-1:0] b,
  output logic signed [grdm_pkg::PROD_W-1:0] prod_r
);
  import grdm_pkg::*;

  // one signed 32x24 product a cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### design/geminal_response_density_matrices_core.sv
// A load, an index error or a trivially zero element passes from idle through the
// hand-off state S_FIN to the output register. A query scans the occupied x virtual
// block (N*(K-N) positions) once, twice for an occupied-virtual pair element and
// not at all for a virtual-occupied one. A pair-product term runs S_R1, S_M1, S_ACC;
// a cross term S_R1, S_R2, S_M1, S_ACC; a triple-product term S_R1-S_R3, S_M1-S_M6.
// One item at a time, set by the single store read port and the one shared multiplier.
// Reset: synchronous, active low; K=16, N=8, idle, output empty; stores are not cleared.
module geminal_response_density_matrices_core #(
  parameter int MAX_ORBITALS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  grdm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output grdm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [grdm_pkg::CFG_W-1:0]     cfg_wdata
);
  import grdm_pkg::*;

  localparam int IW = $clog2(MAX_ORBITALS);  // orbital index bits
  localparam int CW = IW + 1;                // loop counters, can hold K
  localparam int AW = 2 * IW;                // store address {row, col}

  // configuration
  logic [CFG_W-1:0] num_orbitals_r;
  logic [CFG_W-1:0] num_pairs_r;
  logic [CW-1:0]    kk;
  logic [CW-1:0]    np;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_orbitals_r <= NUM_ORBITALS_RST;
      num_pairs_r    <= NUM_PAIRS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ORBITALS: num_orbitals_r <= cfg_wdata;
        CFG_NUM_PAIRS:    num_pairs_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective K and N
  always_comb begin
    kk = (32'(num_orbitals_r) < MAX_ORBITALS) ? CW'(num_orbitals_r) : CW'(MAX_ORBITALS);
    np = (32'(num_pairs_r) < 32'(kk)) ? CW'(num_pairs_r) : kk;
  end

  // sequencer state
  state_t                    state_r, state_nxt;
  job_t                      job_r, job_nxt;
  pass_t                     pass_r, pass_nxt;
  scale_t                    scale_r, scale_nxt;
  logic [IW-1:0]             a_r, a_nxt;
  logic [IW-1:0]             b_r, b_nxt;
  logic                      skip_r, skip_nxt;
  logic                      sub_one_r, sub_one_nxt;
  logic                      fin_r, fin_nxt;
  logic [CW-1:0]             o_r, o_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic signed [DATA_W-1:0]  r1_cf_r, r1_cf_nxt;
  logic signed [DATA_W-1:0]  r1_mu_r, r1_mu_nxt;
  logic signed [DATA_W-1:0]  r2_cf_r, r2_cf_nxt;
  logic signed [DATA_W-1:0]  r3_cf_r, r3_cf_nxt;
  logic signed [DATA_W-1:0]  cfpq_r, cfpq_nxt;
  logic signed [PROD_W-1:0]  t_r, t_nxt;
  logic signed [GG_W-1:0]    gg_r, gg_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   accf_r, accf_nxt;
  logic signed [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic [1:0]                res_st_r, res_st_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  // store and multiplier hookup
  logic                      store_we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic signed [DATA_W-1:0]  rd_cf;
  logic signed [DATA_W-1:0]  rd_mu;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  grdm_store #(.IW(IW)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr),
    .wcf   (in_data.coefficient),
    .wmu   (in_data.multiplier),
    .raddr (raddr),
    .rcf_r (rd_cf),
    .rmu_r (rd_mu)
  );

  grdm_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic          in_acc;
    logic [3:0]    ix_p, ix_q, ix_r, ix_s, ix_d;
    logic          pv, qv, rv, sv, po, qo, dov;
    logic          term2, term3;
    logic [CW-1:0] ea, eb, n_inc;
    logic          inc, is_pr, scan_end, to_scan;
    logic signed [PROD_W-1:0] pr_rnd, t_rnd;
    logic signed [PROD_W:0]   gg_sum;
    logic signed [64:0]       xv;
    logic signed [66:0]       vv;
    logic signed [DATA_W-1:0] bsel;

    state_nxt     = state_r;
    job_nxt       = job_r;
    pass_nxt      = pass_r;
    scale_nxt     = scale_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    skip_nxt      = skip_r;
    sub_one_nxt   = sub_one_r;
    fin_nxt       = fin_r;
    o_nxt         = o_r;
    n_nxt         = n_r;
    r1_cf_nxt     = r1_cf_r;
    r1_mu_nxt     = r1_mu_r;
    r2_cf_nxt     = r2_cf_r;
    r3_cf_nxt     = r3_cf_r;
    cfpq_nxt      = cfpq_r;
    t_nxt         = t_r;
    gg_nxt        = gg_r;
    acc_nxt       = acc_r;
    accf_nxt      = accf_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    store_we      = 1'b0;
    raddr         = {o_r[IW-1:0], n_r[IW-1:0]};
    mul_a         = '0;
    mul_b         = '0;

    in_acc = in_valid && !in_stall;
    ix_p   = in_data.index_p;
    ix_q   = in_data.index_q;
    ix_r   = in_data.index_r;
    ix_s   = in_data.index_s;
    pv     = 32'(ix_p) < 32'(kk);
    qv     = 32'(ix_q) < 32'(kk);
    rv     = 32'(ix_r) < 32'(kk);
    sv     = 32'(ix_s) < 32'(kk);
    po     = 32'(ix_p) < 32'(np);
    qo     = 32'(ix_q) < 32'(np);
    term2  = (ix_p == ix_q) && (ix_r == ix_s) && (ix_p != ix_r);
    term3  = (ix_p == ix_s) && (ix_q == ix_r) && (ix_p != ix_q);
    ix_d   = term2 ? ix_r : ix_q;  // second index of the number-matrix element
    dov    = 32'(ix_d) < 32'(np);
    waddr  = {IW'(ix_p), IW'(ix_q)};

    ea       = {1'b0, a_r};
    eb       = {1'b0, b_r};
    n_inc    = n_r + 1'b1;
    is_pr    = pass_r inside {P_ROW1, P_ROW2, P_COL, P_FS};
    scan_end = (o_r >= np) || (n_r >= kk);
    bsel     = fin_r ? cfpq_r : r1_mu_r;
    to_scan  = 1'b0;

    case (pass_r)
      P_ROW1:  inc = (o_r == ea);
      P_ROW2:  inc = (o_r == ea) || (o_r == eb);
      P_COL:   inc = (n_r == ea) && !(skip_r && (o_r == eb));
      P_FS:    inc = 1'b1;
      P_XSUM:  inc = (o_r == ea);
      P_VV:    inc = (n_r == np);
      P_OV:    inc = (o_r != ea) && (n_r != eb);
      default: inc = 1'b0;
    endcase

    pr_rnd = (prod_r + PROD_W'(128)) >>> 8;
    t_rnd  = (t_r + PROD_W'(524288)) >>> 20;
    gg_sum = (PROD_W+1)'(t_r) + (PROD_W+1)'(prod_r) + (PROD_W+1)'(128);
    xv     = sub_one_r ? (65'(ONE_Q32) - 65'(acc_r)) : 65'(acc_r);

    case (scale_r)
      SC_X4:   vv = {xv, 2'b00};
      SC_NEG2: vv = -{xv[64], xv, 1'b0};
      default: vv = {xv[64], xv, 1'b0};
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_FIN;
          job_nxt     = JOB_PASS;
          scale_nxt   = SC_X2;
          sub_one_nxt = 1'b0;
          skip_nxt    = 1'b0;
          fin_nxt     = 1'b0;
          a_nxt       = IW'(ix_p);
          b_nxt       = IW'(ix_q);
          o_nxt       = '0;
          n_nxt       = np;
          acc_nxt     = '0;
          case (in_data.func)
            FUNC_LOAD: begin
              if (po && !qo && qv) store_we = 1'b1;
              else res_st_nxt = ST_ERR;
            end
            FUNC_RDM1: begin
              if (!pv || !qv) begin
                res_st_nxt = ST_ERR;
              end else if (ix_p == ix_q) begin
                state_nxt = S_SCAN;
                if (po) begin
                  pass_nxt    = P_ROW1;
                  sub_one_nxt = 1'b1;
                end else begin
                  pass_nxt = P_COL;
                end
              end
            end
            FUNC_RDM2: begin
              if (!pv || !qv || !rv || !sv) begin
                res_st_nxt = ST_ERR;
              end else if ((ix_p == ix_r) && (ix_q == ix_s)) begin
                // pair-matrix element, doubled
                state_nxt = S_SCAN;
                if (po && qo) begin
                  pass_nxt    = P_XSUM;
                  sub_one_nxt = (ix_p == ix_q);
                end else if (po) begin
                  job_nxt   = JOB_PI_OV;
                  pass_nxt  = P_FS;
                  state_nxt = S_PRE;
                end else if (qo) begin
                  job_nxt   = JOB_PI_VO;
                  state_nxt = S_PRE;
                end else begin
                  pass_nxt = P_VV;
                end
              end else if (term2 || term3) begin
                // number-matrix element: 4X, or -2X for the exchange term
                scale_nxt = term2 ? SC_X4 : SC_NEG2;
                state_nxt = S_SCAN;
                if (po && dov) begin
                  pass_nxt    = P_ROW2;
                  b_nxt       = IW'(ix_d);
                  sub_one_nxt = 1'b1;
                end else if (po) begin
                  pass_nxt = P_COL;
                  a_nxt    = IW'(ix_d);
                  b_nxt    = IW'(ix_p);
                  skip_nxt = 1'b1;
                end else if (dov) begin
                  pass_nxt = P_COL;
                  b_nxt    = IW'(ix_d);
                  skip_nxt = 1'b1;
                end else begin
                  state_nxt = S_FIN;  // both virtual and distinct
                end
              end
            end
            default: res_st_nxt = ST_ERR;
          endcase
        end
      end

      S_PRE: begin
        raddr     = (job_r == JOB_PI_OV) ? {a_r, b_r} : {b_r, a_r};
        state_nxt = S_PRE2;
      end

      S_PRE2: begin
        if (job_r == JOB_PI_OV) begin
          cfpq_nxt  = rd_cf;
          state_nxt = S_SCAN;
        end else begin
          acc_nxt   = ACC_W'(rd_mu) <<< 12;
          state_nxt = S_RES;
        end
      end

      S_SCAN: begin
        case (pass_r)
          P_XSUM:  raddr = {b_r, n_r[IW-1:0]};
          P_VV:    raddr = {o_r[IW-1:0], a_r};
          default: raddr = {o_r[IW-1:0], n_r[IW-1:0]};
        endcase
        if (scan_end) begin
          if ((job_r == JOB_PI_OV) && (pass_r == P_FS)) begin
            accf_nxt = acc_r;
            acc_nxt  = '0;
            pass_nxt = P_OV;
            o_nxt    = '0;
            n_nxt    = np;
          end else if (job_r == JOB_PI_OV) begin
            gg_nxt    = GG_W'(ONE_Q32 - accf_r);
            fin_nxt   = 1'b1;
            state_nxt = S_M4;
          end else begin
            state_nxt = S_RES;
          end
        end else if (inc) begin
          state_nxt = S_R1;
        end else begin
          to_scan = 1'b1;
        end
      end

      S_R1: begin
        r1_cf_nxt = rd_cf;
        r1_mu_nxt = rd_mu;
        case (pass_r)
          P_XSUM:  raddr = {o_r[IW-1:0], n_r[IW-1:0]};
          default: raddr = {o_r[IW-1:0], b_r};
        endcase
        state_nxt = is_pr ? S_M1 : S_R2;
      end

      S_R2: begin
        r2_cf_nxt = rd_cf;
        raddr     = {a_r, n_r[IW-1:0]};
        state_nxt = (pass_r == P_OV) ? S_R3 : S_M1;
      end

      S_R3: begin
        r3_cf_nxt = rd_cf;
        state_nxt = S_M1;
      end

      S_M1: begin
        if (is_pr) begin
          mul_a = MA_W'(r1_mu_r);
          mul_b = r1_cf_r;
          state_nxt = S_ACC;
        end else if (pass_r == P_OV) begin
          mul_a = MA_W'(cfpq_r);
          mul_b = r1_cf_r;
          state_nxt = S_M2;
        end else begin
          mul_a = MA_W'(r1_mu_r);
          mul_b = r2_cf_r;
          state_nxt = S_ACC;
        end
      end

      S_M2: begin
        t_nxt     = prod_r;
        mul_a     = MA_W'(r2_cf_r);
        mul_b     = r3_cf_r;
        state_nxt = S_M3;
      end

      S_M3: begin
        gg_nxt    = GG_W'(gg_sum >>> 8);
        state_nxt = S_M4;
      end

      S_M4: begin
        mul_a     = MA_W'({1'b0, gg_r[19:0]});
        mul_b     = bsel;
        state_nxt = S_M5;
      end

      S_M5: begin
        t_nxt     = prod_r;
        mul_a     = gg_r[GG_W-1:20];
        mul_b     = bsel;
        state_nxt = S_M6;
      end

      S_M6: begin
        // round(x*g/2^20) = hi*g + round(lo*g/2^20)
        acc_nxt = acc_r + ACC_W'(prod_r) + ACC_W'(t_rnd);
        if (fin_r) state_nxt = S_RES;
        else to_scan = 1'b1;
      end

      S_ACC: begin
        acc_nxt = acc_r + ACC_W'(pr_rnd);
        to_scan = 1'b1;
      end

      S_RES: begin
        if (vv > SAT_MAX) begin
          res_val_nxt = SAT_MAX[VALUE_W-1:0];
          res_st_nxt  = ST_SAT;
        end else if (vv < SAT_MIN) begin
          res_val_nxt = SAT_MIN[VALUE_W-1:0];
          res_st_nxt  = ST_SAT;
        end else begin
          res_val_nxt = vv[VALUE_W-1:0];
          res_st_nxt  = ST_OK;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = res_val_r;
          out_data_nxt.status = res_st_r;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // step through the occupied x virtual block, row by row
    if (to_scan) begin
      state_nxt = S_SCAN;
      if (n_inc == kk) begin
        n_nxt = np;
        o_nxt = o_r + 1'b1;
      end else begin
        n_nxt = n_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    pass_r     <= pass_nxt;
    scale_r    <= scale_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    skip_r     <= skip_nxt;
    sub_one_r  <= sub_one_nxt;
    fin_r      <= fin_nxt;
    o_r        <= o_nxt;
    n_r        <= n_nxt;
    r1_cf_r    <= r1_cf_nxt;
    r1_mu_r    <= r1_mu_nxt;
    r2_cf_r    <= r2_cf_nxt;
    r3_cf_r    <= r3_cf_nxt;
    cfpq_r     <= cfpq_nxt;
    t_r        <= t_nxt;
    gg_r       <= gg_nxt;
    acc_r      <= acc_nxt;
    accf_r     <= accf_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  // stores are written only on the transfer of a load
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |-> (state_r == S_IDLE) && in_valid && (in_data.func == FUNC_LOAD))
    else $error("store written outside a load transfer");

  // a transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("transfer did not leave idle");

  // a result appears only from the hand-off state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside hand-off");

  // a term is only ever taken inside the occupied x virtual block
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M1) |-> ((o_r < np) && (n_r < kk) && (n_r >= np)))
    else $error("term outside block");
`endif

endmodule
